>>> hw/rtl/dxt_pkg.sv
package dxt_pkg;

	// default for the largest image side handled
	localparam int MAX_DIM_DEF = 4096;

	// width of the image size registers and of the config data
	localparam int CFG_DIM_W = 13;
	localparam int CFG_IDX_W = 2;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

	// block format codes, anything else decodes as dxt5
	localparam logic [1:0] FMT_DXT1 = 2'd0;
	localparam logic [1:0] FMT_DXT3 = 2'd1;

	// color index that reads as transparent black in three-color dxt1 blocks
	localparam logic [1:0] IDX_TRANSPARENT = 2'd3;

	// first bit of the dxt5 3-bit alpha indexes in the alpha block
	localparam logic [5:0] ALPHA_IDX_LSB = 6'd16;

	// reciprocals for exact floor division over the value ranges used here
	localparam logic [15:0] RECIP31 = 16'd33826; // 2^20/31, exact below 34952
	localparam logic [15:0] RECIP63 = 16'd16645; // 2^20/63, exact below 17772
	localparam logic [11:0] RECIP7  = 12'd2341;  // 2^14/7, exact below 5461
	localparam logic [11:0] RECIP5  = 12'd3277;  // 2^14/5, exact below 16384
	localparam logic [9:0]  RECIP3  = 10'd683;   // 2^11/3, exact below 2048

	// per-block fields that ride along with the palettes
	typedef struct packed {
		logic        is_dxt1;
		logic        is_dxt3;
		logic        four;
		logic        swap_rb;
		logic [9:0]  bx;
		logic [9:0]  by;
		logic [1:0]  ncol_m1;
		logic [1:0]  nrow_m1;
		logic [31:0] cidx;
		logic [63:0] abits;
	} dxt_meta_t;

	// one decoded block as handed from front to back
	typedef struct packed {
		dxt_meta_t       meta;
		logic [3:0][7:0] red;
		logic [3:0][7:0] grn;
		logic [3:0][7:0] blu;
		logic [7:0][7:0] apal;
	} dxt_desc_t;

	function automatic logic [7:0] div31(input logic [13:0] m);
		logic [29:0] p;
		p = 30'(m) * 30'(RECIP31);
		return p[27:20];
	endfunction

	function automatic logic [7:0] div63(input logic [13:0] m);
		logic [29:0] p;
		p = 30'(m) * 30'(RECIP63);
		return p[27:20];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] m);
		logic [24:0] p;
		p = 25'(m) * 25'(RECIP7);
		return p[21:14];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] m);
		logic [24:0] p;
		p = 25'(m) * 25'(RECIP5);
		return p[21:14];
	endfunction

	function automatic logic [7:0] div3(input logic [9:0] m);
		logic [20:0] p;
		p = 21'(m) * 21'(RECIP3);
		return p[18:11];
	endfunction

endpackage

>>> hw/rtl/dxt_block_decoder.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------
// input     | in        | push / full           | color_block, alpha_block
// result    | out       | empty / pop           | pixel_word, pixel_x, pixel_y, block_last
// config    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Pixels leave at one per cycle from the output register while pop keeps it free and
// a decoded block is ready, so a block yields as many pixels as lie inside the image
// (sixteen for an interior block); the back walker sets this pace. The front registers
// an accepted request in stage 1 and stage 2 before it reaches the queue, and a block
// with no pixel inside is dropped in the front without entering the queue.
// Reset is asynchronous: config returns to DXT1, A8R8G8B8, 4096x4096, position 0.
// The front stalls (full high) only when a block with pixels waits on a full queue.
module dxt_block_decoder #(
	parameter int MAX_DIMENSION = dxt_pkg::MAX_DIM_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [63:0]                   color_block,
	input  logic [63:0]                   alpha_block,
	output logic                          empty,
	input  logic                          pop,
	output logic [31:0]                   pixel_word,
	output logic [11:0]                   pixel_x,
	output logic [11:0]                   pixel_y,
	output logic                          block_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dxt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dxt_pkg::CFG_DIM_W-1:0] cfg_data
);

	logic               q_push, q_full, q_pop, q_empty;
	dxt_pkg::dxt_desc_t q_wdata, q_rdata;

	// decode front: position, clipping and palettes
	dxt_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.color_block(color_block),
		.alpha_block(alpha_block),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.q_full     (q_full)
	);

	// decoded block queue
	dxt_fifo #(
		.DEPTH(dxt_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rdata),
		.q_empty(q_empty)
	);

	// pixel walker and output register
	dxt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.pixel_word(pixel_word),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.block_last(block_last)
	);

endmodule

>>> hw/rtl/dxt_front.sv
module dxt_front #(
	parameter int MAX_DIMENSION = dxt_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [63:0]                    color_block,
	input  logic [63:0]                    alpha_block,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dxt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dxt_pkg::CFG_DIM_W-1:0]  cfg_data,
	output logic                           q_push,
	output dxt_pkg::dxt_desc_t             q_data,
	input  logic                           q_full
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int BLK_N = (MAX_DIMENSION + 3) / 4;
	localparam int BLK_W = (BLK_N > 1) ? $clog2(BLK_N) : 1;
	localparam int CW    = (DIM_W > dxt_pkg::CFG_DIM_W) ? DIM_W : dxt_pkg::CFG_DIM_W;
	localparam int PW    = (BLK_W + 2 > DIM_W) ? BLK_W + 2 : DIM_W;
	localparam int AW    = PW + 1;

	// size register to effective size, zero acts as one, large acts as max
	function automatic logic [DIM_W-1:0] dim_clamp(input logic [dxt_pkg::CFG_DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (CW'(v) > CW'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	logic [1:0]                    fmt_q;
	logic                          swap_q;
	logic [dxt_pkg::CFG_DIM_W-1:0] width_q;
	logic [dxt_pkg::CFG_DIM_W-1:0] height_q;
	logic [BLK_W-1:0]              col_q;
	logic [BLK_W-1:0]              row_q;

	logic             adv;
	logic             accept;
	logic [DIM_W-1:0] w_cl, h_cl;
	logic [AW-1:0]    x0, y0, rem_x, rem_y, bw, bh, col_nx, row_nx;
	logic             in_x, in_y;

	logic [4:0] r0, r1, b0, b1;
	logic [5:0] g0, g1;
	logic [7:0] a0, a1;
	logic       ahi;
	logic [10:0] asum [2:7];

	logic               v_s1, v_s2;
	logic               void_s1, void_s2;
	dxt_pkg::dxt_meta_t meta_s1, meta_s2, meta_in;
	logic [13:0]        mr_s1 [4];
	logic [13:0]        mg_s1 [4];
	logic [13:0]        mb_s1 [4];
	logic [10:0]        asum_s1 [2:7];
	logic               ahi_s1;
	logic [7:0]         a0_s1, a1_s1;
	logic [3:0][7:0]    red_s2, grn_s2, blu_s2;
	logic [7:0][7:0]    apal_s2;

	// config writes, always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= dxt_pkg::FMT_DXT1;
			swap_q   <= 1'b0;
			width_q  <= dxt_pkg::CFG_DIM_W'(4096);
			height_q <= dxt_pkg::CFG_DIM_W'(4096);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dxt_pkg::REG_FORMAT: fmt_q    <= cfg_data[1:0];
				dxt_pkg::REG_ORDER:  swap_q   <= cfg_data[0];
				dxt_pkg::REG_WIDTH:  width_q  <= cfg_data;
				dxt_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall only when a block with pixels waits on a full queue
	assign adv    = !(v_s2 && !void_s2 && q_full);
	assign full   = !adv;
	assign accept = push && adv;
	assign q_push = v_s2 && !void_s2 && !q_full;

	// block position against the clipped image
	always_comb begin
		w_cl   = dim_clamp(width_q);
		h_cl   = dim_clamp(height_q);
		x0     = AW'({col_q, 2'b00});
		y0     = AW'({row_q, 2'b00});
		in_x   = x0 < AW'(w_cl);
		in_y   = y0 < AW'(h_cl);
		rem_x  = AW'(w_cl) - x0;
		rem_y  = AW'(h_cl) - y0;
		bw     = (AW'(w_cl) + AW'(3)) >> 2;
		bh     = (AW'(h_cl) + AW'(3)) >> 2;
		col_nx = AW'(col_q) + AW'(1);
		row_nx = AW'(row_q) + AW'(1);
	end

	// block position counter, wraps at row end and image end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_nx >= bw) begin
				col_q <= '0;
				row_q <= (row_nx >= bh) ? '0 : BLK_W'(row_nx);
			end else begin
				col_q <= BLK_W'(col_nx);
			end
		end
	end

	// field split and classification of the incoming block
	always_comb begin
		r0  = color_block[15:11];
		g0  = color_block[10:5];
		b0  = color_block[4:0];
		r1  = color_block[31:27];
		g1  = color_block[26:21];
		b1  = color_block[20:16];
		a0  = alpha_block[7:0];
		a1  = alpha_block[15:8];
		ahi = a0 > a1;
		for (int k = 2; k < 8; k++) begin
			if (ahi || k > 5) begin
				asum[k] = 11'(8 - k) * 11'(a0) + 11'(k - 1) * 11'(a1);
			end else begin
				asum[k] = 11'(6 - k) * 11'(a0) + 11'(k - 1) * 11'(a1);
			end
		end
		meta_in.is_dxt1 = fmt_q == dxt_pkg::FMT_DXT1;
		meta_in.is_dxt3 = fmt_q == dxt_pkg::FMT_DXT3;
		meta_in.four    = color_block[15:0] > color_block[31:16];
		meta_in.swap_rb = swap_q;
		meta_in.bx      = 10'(col_q);
		meta_in.by      = 10'(row_q);
		meta_in.ncol_m1 = (rem_x >= AW'(4)) ? 2'd3 : 2'(rem_x - AW'(1));
		meta_in.nrow_m1 = (rem_y >= AW'(4)) ? 2'd3 : 2'(rem_y - AW'(1));
		meta_in.cidx    = color_block[63:32];
		meta_in.abits   = alpha_block;
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// stage 1: endpoint and mix products
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1  <= meta_in;
			void_s1  <= !(in_x && in_y);
			mr_s1[0] <= 14'(r0) * 14'(255);
			mr_s1[1] <= 14'(r1) * 14'(255);
			mr_s1[2] <= (14'({r0, 1'b0}) + 14'(r1)) * 14'(85);
			mr_s1[3] <= (14'(r0) + 14'({r1, 1'b0})) * 14'(85);
			mg_s1[0] <= 14'(g0) * 14'(255);
			mg_s1[1] <= 14'(g1) * 14'(255);
			mg_s1[2] <= (14'({g0, 1'b0}) + 14'(g1)) * 14'(85);
			mg_s1[3] <= (14'(g0) + 14'({g1, 1'b0})) * 14'(85);
			mb_s1[0] <= 14'(b0) * 14'(255);
			mb_s1[1] <= 14'(b1) * 14'(255);
			mb_s1[2] <= (14'({b0, 1'b0}) + 14'(b1)) * 14'(85);
			mb_s1[3] <= (14'(b0) + 14'({b1, 1'b0})) * 14'(85);
			for (int k = 2; k < 8; k++) begin
				asum_s1[k] <= asum[k];
			end
			ahi_s1 <= ahi;
			a0_s1  <= a0;
			a1_s1  <= a1;
		end
	end

	// stage 2: divisions by reciprocal, alpha palette
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_s1;
			void_s2 <= void_s1;
			for (int c = 0; c < 4; c++) begin
				red_s2[c] <= dxt_pkg::div31(mr_s1[c]);
				grn_s2[c] <= dxt_pkg::div63(mg_s1[c]);
				blu_s2[c] <= dxt_pkg::div31(mb_s1[c]);
			end
			apal_s2[0] <= a0_s1;
			apal_s2[1] <= a1_s1;
			for (int k = 2; k < 8; k++) begin
				if (ahi_s1) begin
					apal_s2[k] <= dxt_pkg::div7(asum_s1[k]);
				end else if (k < 6) begin
					apal_s2[k] <= dxt_pkg::div5(asum_s1[k]);
				end else if (k == 6) begin
					apal_s2[k] <= 8'h00;
				end else begin
					apal_s2[k] <= 8'hff;
				end
			end
		end
	end

	// stage 3: dxt1 thirds or midpoint, final palette to the queue
	always_comb begin
		q_data.meta = meta_s2;
		q_data.apal = apal_s2;
		q_data.red  = red_s2;
		q_data.grn  = grn_s2;
		q_data.blu  = blu_s2;
		if (meta_s2.is_dxt1) begin
			if (meta_s2.four) begin
				q_data.red[2] = dxt_pkg::div3(10'({red_s2[0], 1'b0}) + 10'(red_s2[1]));
				q_data.red[3] = dxt_pkg::div3(10'(red_s2[0]) + 10'({red_s2[1], 1'b0}));
				q_data.grn[2] = dxt_pkg::div3(10'({grn_s2[0], 1'b0}) + 10'(grn_s2[1]));
				q_data.grn[3] = dxt_pkg::div3(10'(grn_s2[0]) + 10'({grn_s2[1], 1'b0}));
				q_data.blu[2] = dxt_pkg::div3(10'({blu_s2[0], 1'b0}) + 10'(blu_s2[1]));
				q_data.blu[3] = dxt_pkg::div3(10'(blu_s2[0]) + 10'({blu_s2[1], 1'b0}));
			end else begin
				q_data.red[2] = 8'((9'(red_s2[0]) + 9'(red_s2[1])) >> 1);
				q_data.grn[2] = 8'((9'(grn_s2[0]) + 9'(grn_s2[1])) >> 1);
				q_data.blu[2] = 8'((9'(blu_s2[0]) + 9'(blu_s2[1])) >> 1);
				q_data.red[3] = 8'h00;
				q_data.grn[3] = 8'h00;
				q_data.blu[3] = 8'h00;
			end
		end
	end

endmodule

>>> hw/rtl/dxt_fifo.sv
module dxt_fifo #(
	parameter int DEPTH = dxt_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  dxt_pkg::dxt_desc_t wr_data,
	output logic               q_full,
	input  logic               rd_en,
	output dxt_pkg::dxt_desc_t rd_data,
	output logic               q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dxt_pkg::dxt_desc_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign q_full  = count_q == CNT_W'(DEPTH);
	assign q_empty = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/dxt_back.sv
module dxt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  dxt_pkg::dxt_desc_t q_data,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        pixel_word,
	output logic [11:0]        pixel_x,
	output logic [11:0]        pixel_y,
	output logic               block_last
);

	dxt_pkg::dxt_desc_t cur_q;
	logic               act_q;
	logic [1:0]         i_q, j_q;
	logic               out_v_q;

	logic        out_free, step, last_pix, done;
	logic [3:0]  pos;
	logic [1:0]  ci;
	logic [3:0]  nib;
	logic [5:0]  aoff;
	logic [2:0]  ai;
	logic [7:0]  alpha, hi, lo;
	logic [31:0] word;

	// walk control: one pixel whenever the output slot frees up and a block is active
	assign out_free = !out_v_q || pop;
	assign step     = act_q && out_free;
	assign last_pix = (i_q == cur_q.meta.nrow_m1) && (j_q == cur_q.meta.ncol_m1);
	assign done     = step && last_pix;
	assign q_pop    = (!act_q || done) && !q_empty;
	assign empty    = !out_v_q;

	// block walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			i_q   <= '0;
			j_q   <= '0;
		end else begin
			if (q_pop) begin
				act_q <= 1'b1;
				i_q   <= '0;
				j_q   <= '0;
			end else begin
				if (done) begin
					act_q <= 1'b0;
				end
				if (step) begin
					if (j_q == cur_q.meta.ncol_m1) begin
						j_q <= '0;
						i_q <= i_q + 2'd1;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
			end
		end
	end

	// current block
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	// pixel lookup
	always_comb begin
		pos  = {i_q, j_q};
		ci   = cur_q.meta.cidx[{pos, 1'b0} +: 2];
		nib  = cur_q.meta.abits[{pos, 2'b00} +: 4];
		aoff = dxt_pkg::ALPHA_IDX_LSB + 6'(pos) + 6'({pos, 1'b0});
		ai   = cur_q.meta.abits[aoff +: 3];
		if (cur_q.meta.is_dxt1) begin
			alpha = 8'hff;
		end else if (cur_q.meta.is_dxt3) begin
			alpha = {nib, nib};
		end else begin
			alpha = cur_q.apal[ai];
		end
		hi   = cur_q.meta.swap_rb ? cur_q.blu[ci] : cur_q.red[ci];
		lo   = cur_q.meta.swap_rb ? cur_q.red[ci] : cur_q.blu[ci];
		word = {alpha, hi, cur_q.grn[ci], lo};
		if (cur_q.meta.is_dxt1 && !cur_q.meta.four && ci == dxt_pkg::IDX_TRANSPARENT) begin
			word = '0;
		end
	end

	// output slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= step;
		end
	end

	// output slot payload
	always_ff @(posedge clk) begin
		if (step) begin
			pixel_word <= word;
			pixel_x    <= {cur_q.meta.bx, j_q};
			pixel_y    <= {cur_q.meta.by, i_q};
			block_last <= last_pix;
		end
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_SIDE = dxt_pkg::MAX_DIM_DEF;
	// front latency plus margin, covers blocks that emit nothing
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BLOCKS = 88;
	localparam int SCRIPT_LEN = 35;
	localparam logic [1:0] FMT_DXT5 = 2'd2;
	localparam logic [1:0] FMT_SPARE = 2'd3;

	typedef struct packed {
		logic [31:0] word;
		logic [11:0] x;
		logic [11:0] y;
		logic        last;
	} pixel_t;

	// one directed row: a register write or a block, with an optional fixed pixel word
	typedef struct packed {
		logic                          is_cfg;
		logic [dxt_pkg::CFG_IDX_W-1:0] idx;
		logic [dxt_pkg::CFG_DIM_W-1:0] value;
		logic [63:0]                   cb;
		logic [63:0]                   ab;
		logic                          typed;
		logic [31:0]                   word;
	} step_t;

	localparam step_t SCRIPT [SCRIPT_LEN] = '{
		// dxt1 after reset: white, transparent black, color1 blue, all zero
		'{1'b0, '0, '0, 64'h0000_0000_0000_FFFF, 64'h0, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, '0, '0, 64'hFFFF_FFFF_FFFF_0000, 64'h0, 1'b1, 32'h0000_0000},
		'{1'b0, '0, '0, 64'h5555_5555_001F_F800, 64'h0, 1'b1, 32'hFF00_00FF},
		'{1'b0, '0, '0, 64'h0000_0000_0000_0000, 64'h0, 1'b1, 32'hFF00_0000},
		'{1'b0, '0, '0, 64'hE4E4_E4E4_7BEF_A534, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'hAAAA_5555_F800_001F, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h1B1B_1B1B_1234_1234, 64'h0, 1'b0, 32'h0},
		// red and blue swapped
		'{1'b1, dxt_pkg::REG_ORDER, 13'd1, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h0000_0000_0000_F800, 64'h0, 1'b1, 32'hFF00_00FF},
		'{1'b0, '0, '0, 64'h39C6_E4E4_07E0_F81F, 64'h5A5A_C3C3_0F0F_9696, 1'b0, 32'h0},
		// explicit alpha
		'{1'b1, dxt_pkg::REG_FORMAT, 13'(dxt_pkg::FMT_DXT3), 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFF00_0000},
		'{1'b0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 32'h00FF_FFFF},
		'{1'b0, '0, '0, 64'h9C63_36D8_4210_C618, 64'h0123_4567_89AB_CDEF, 1'b0, 32'h0},
		// interpolated alpha, both palette kinds
		'{1'b1, dxt_pkg::REG_FORMAT, 13'(FMT_DXT5), 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b1, dxt_pkg::REG_ORDER, 13'd0, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_00FF, 1'b1, 32'h24FF_FFFF},
		'{1'b0, '0, '0, 64'hB1E4_4E1B_F81F_07E0, 64'hDB6D_B6DB_6DB6_FF00, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h0, 64'h0, 1'b1, 32'h0000_0000},
		// unused format code
		'{1'b1, dxt_pkg::REG_FORMAT, 13'(FMT_SPARE), 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h72D1_8E4B_A5F0_3C1E, 64'h2492_4924_9249_24A0, 1'b0, 32'h0},
		// zero sizes act as one, position now past the image
		'{1'b1, dxt_pkg::REG_WIDTH, 13'd0, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b1, dxt_pkg::REG_HEIGHT, 13'd0, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h5555_5555_0000_FFFF, 64'h1234_5678_9ABC_DEF0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_00FF, 1'b1, 32'h24FF_FFFF},
		// oversize width clamps, partial blocks on the right and bottom edges
		'{1'b1, dxt_pkg::REG_WIDTH, 13'd8191, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b1, dxt_pkg::REG_HEIGHT, 13'd6, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h0F1E_2D3C_8410_7BEF, 64'hC0FF_EE00_1234_80FF, 1'b0, 32'h0},
		'{1'b1, dxt_pkg::REG_WIDTH, 13'd6, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'hE1D2_C3B4_1111_2222, 64'h7777_8888_9999_40C0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'h3C3C_C3C3_FFE0_001F, 64'hAAAA_5555_AAAA_10F0, 1'b0, 32'h0},
		'{1'b1, dxt_pkg::REG_WIDTH, 13'd4096, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b1, dxt_pkg::REG_HEIGHT, 13'd4096, 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b1, dxt_pkg::REG_FORMAT, 13'(dxt_pkg::FMT_DXT1), 64'h0, 64'h0, 1'b0, 32'h0},
		'{1'b0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h0}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	logic [63:0]                   color_block = '0;
	logic [63:0]                   alpha_block = '0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic [31:0]                   pixel_word;
	logic [11:0]                   pixel_x;
	logic [11:0]                   pixel_y;
	logic                          block_last;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [dxt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dxt_pkg::CFG_DIM_W-1:0] cfg_data = '0;

	dxt_block_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.color_block(color_block),
		.alpha_block(alpha_block),
		.empty(empty),
		.pop(pop),
		.pixel_word(pixel_word),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.block_last(block_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the decoder's registers and block position
	logic [1:0]                    cur_format = dxt_pkg::FMT_DXT1;
	logic                          cur_swap = 1'b0;
	logic [dxt_pkg::CFG_DIM_W-1:0] cur_width = 13'd4096;
	logic [dxt_pkg::CFG_DIM_W-1:0] cur_height = 13'd4096;
	int unsigned                   blk_col = 0;
	int unsigned                   blk_row = 0;

	pixel_t pending_pixels[$];

	int  mismatches = 0;
	int  pixels_checked = 0;
	int  blocks_sent = 0;
	int  empty_blocks = 0;
	int  cfg_writes = 0;
	int  idle_left = 0;
	bit  push_held = 1'b0;
	bit  tx_burst = 1'b0;
	bit  rx_burst = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
	endtask

	function automatic int unsigned clamp_side(input logic [dxt_pkg::CFG_DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_SIDE)
			return MAX_SIDE;
		return v;
	endfunction

	// four palette levels of one channel from its raw endpoint fields
	function automatic logic [3:0][7:0] chan_levels(input int unsigned v0, input int unsigned v1,
			input int unsigned top, input bit dxt1, input bit four);
		logic [3:0][7:0] lv;
		int unsigned     e0;
		int unsigned     e1;
		e0 = v0 * 255 / top;
		e1 = v1 * 255 / top;
		lv[0] = 8'(e0);
		lv[1] = 8'(e1);
		if (!dxt1) begin
			lv[2] = 8'((2 * v0 + v1) * 255 / (3 * top));
			lv[3] = 8'((v0 + 2 * v1) * 255 / (3 * top));
		end else if (four) begin
			lv[2] = 8'((2 * e0 + e1) / 3);
			lv[3] = 8'((e0 + 2 * e1) / 3);
		end else begin
			lv[2] = 8'((e0 + e1) / 2);
			lv[3] = 8'd0;
		end
		return lv;
	endfunction

	// expected pixels of one block at the current position, then advance the position
	task automatic decode_block(input logic [63:0] cb, input logic [63:0] ab,
			input bit pin_word, input logic [31:0] pinned);
		logic [15:0]     c0;
		logic [15:0]     c1;
		logic [3:0][7:0] rl;
		logic [3:0][7:0] gl;
		logic [3:0][7:0] bl;
		logic [7:0][7:0] ap;
		logic [7:0]      a;
		logic [7:0]      hi;
		logic [7:0]      lo;
		logic [1:0]      ci;
		bit              dxt1;
		bit              dxt3;
		bit              four;
		int unsigned     w;
		int unsigned     h;
		int unsigned     x;
		int unsigned     y;
		int              i;
		int              j;
		int              k;
		int              n;
		pixel_t          found [16];
		pixel_t          p;
		c0 = cb[15:0];
		c1 = cb[31:16];
		dxt1 = (cur_format == dxt_pkg::FMT_DXT1);
		dxt3 = (cur_format == dxt_pkg::FMT_DXT3);
		four = (c0 > c1);
		w = clamp_side(cur_width);
		h = clamp_side(cur_height);
		rl = chan_levels(c0[15:11], c1[15:11], 31, dxt1, four);
		gl = chan_levels(c0[10:5], c1[10:5], 63, dxt1, four);
		bl = chan_levels(c0[4:0], c1[4:0], 31, dxt1, four);

		// alpha palette, six or four interpolants
		ap[0] = ab[7:0];
		ap[1] = ab[15:8];
		for (k = 2; k < 8; k++) begin
			if (ap[0] > ap[1])
				ap[k] = 8'(((8 - k) * ap[0] + (k - 1) * ap[1]) / 7);
			else if (k < 6)
				ap[k] = 8'(((6 - k) * ap[0] + (k - 1) * ap[1]) / 5);
			else
				ap[k] = (k == 6) ? 8'd0 : 8'd255;
		end

		// pixels inside the image, row by row
		n = 0;
		for (i = 0; i < 4; i++) begin
			for (j = 0; j < 4; j++) begin
				x = blk_col * 4 + j;
				y = blk_row * 4 + i;
				if (x < w && y < h) begin
					ci = cb[32 + 8 * i + 2 * j +: 2];
					if (dxt1)
						a = 8'hFF;
					else if (dxt3)
						a = 8'(ab[16 * i + 4 * j +: 4] * 17);
					else
						a = ap[ab[16 + 3 * (4 * i + j) +: 3]];
					hi = cur_swap ? bl[ci] : rl[ci];
					lo = cur_swap ? rl[ci] : bl[ci];
					p.word = {a, hi, gl[ci], lo};
					if (dxt1 && !four && ci == dxt_pkg::IDX_TRANSPARENT)
						p.word = '0;
					if (pin_word)
						p.word = pinned;
					p.x = 12'(x);
					p.y = 12'(y);
					p.last = 1'b0;
					found[n] = p;
					n++;
				end
			end
		end
		for (k = 0; k < n; k++) begin
			p = found[k];
			p.last = (k == n - 1);
			pending_pixels.push_back(p);
		end
		if (n == 0)
			empty_blocks++;

		// raster walk with wrap at the end of the image
		blk_col++;
		if (blk_col >= (w + 3) / 4) begin
			blk_col = 0;
			blk_row++;
			if (blk_row >= (h + 3) / 4)
				blk_row = 0;
		end
	endtask

	// one block request; push stays high when the next one follows at once
	task automatic send_block(input logic [63:0] cb, input logic [63:0] ab,
			input bit pin_word, input logic [31:0] pinned);
		repeat (idle_left) @(negedge clk);
		push <= 1'b1;
		color_block <= cb;
		alpha_block <= ab;
		@(posedge clk);
		while (full)
			@(posedge clk);
		decode_block(cb, ab, pin_word, pinned);
		blocks_sent++;
		@(negedge clk);
		idle_left = tx_burst ? 0 : $urandom_range(0, 13);
		push_held = (idle_left == 0);
		if (!push_held)
			push <= 1'b0;
	endtask

	// decoder goes idle: every pixel back, then room for a block with no pixel
	task automatic wait_drained();
		if (push_held) begin
			push <= 1'b0;
			push_held = 1'b0;
		end
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [dxt_pkg::CFG_IDX_W-1:0] idx,
			input logic [dxt_pkg::CFG_DIM_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			dxt_pkg::REG_FORMAT: cur_format = value[1:0];
			dxt_pkg::REG_ORDER:  cur_swap = value[0];
			dxt_pkg::REG_WIDTH:  cur_width = value;
			dxt_pkg::REG_HEIGHT: cur_height = value;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// image side: mostly small, sometimes zero, one, the maximum or above it
	function automatic logic [dxt_pkg::CFG_DIM_W-1:0] pick_side();
		case ($urandom_range(0, 9))
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'($urandom_range(4097, 8191));
			default: return 13'($urandom_range(1, 24));
		endcase
	endfunction

	// result side: random pop stalls, checked against the oldest expected pixel
	initial begin : drain_results
		int unsigned stall;
		pixel_t      want;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with nothing expected", pixel_word, 32'h0);
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_word !== want.word)
					report_mismatch("pixel_word", pixel_word, want.word);
				if (pixel_x !== want.x)
					report_mismatch("pixel_x", 32'(pixel_x), 32'(want.x));
				if (pixel_y !== want.y)
					report_mismatch("pixel_y", 32'(pixel_y), 32'(want.y));
				if (block_last !== want.last)
					report_mismatch("block_last", 32'(block_last), 32'(want.last));
				pixels_checked++;
			end
			if ($urandom_range(0, 31) == 0)
				rx_burst = !rx_burst;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int          i;
		int          r;
		int          run_len;
		int          random_blocks;
		logic [63:0] cb;
		logic [63:0] ab;
		random_blocks = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (i = 0; i < SCRIPT_LEN; i++) begin
			if (SCRIPT[i].is_cfg) begin
				wait_drained();
				write_reg(SCRIPT[i].idx, SCRIPT[i].value);
			end else begin
				send_block(SCRIPT[i].cb, SCRIPT[i].ab, SCRIPT[i].typed, SCRIPT[i].word);
			end
		end

		// random phases, new settings for each
		while (random_blocks < RANDOM_BLOCKS) begin
			wait_drained();
			write_reg(dxt_pkg::REG_FORMAT, 13'($urandom_range(0, 3)));
			write_reg(dxt_pkg::REG_ORDER, 13'($urandom_range(0, 1)));
			write_reg(dxt_pkg::REG_WIDTH, pick_side());
			write_reg(dxt_pkg::REG_HEIGHT, pick_side());
			tx_burst = ($urandom_range(0, 3) == 0);
			run_len = $urandom_range(4, 16);
			for (r = 0; r < run_len && random_blocks < RANDOM_BLOCKS; r++) begin
				// at block 40 and now and then at random, the sender holds off until the decoder has emptied
				if (random_blocks == 40 || $urandom_range(0, 19) == 0)
					wait_drained();
				cb = {$urandom, $urandom};
				ab = {$urandom, $urandom};
				case ($urandom_range(0, 7))
					0: cb[31:16] = cb[15:0];
					1: cb[63:32] = {16{cb[33:32]}};
					2: ab[15:8] = ab[7:0];
					default: ;
				endcase
				send_block(cb, ab, 1'b0, 32'h0);
				random_blocks++;
			end
		end

		wait_drained();
		repeat (4 * SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d blocks (%0d with no pixel inside), %0d pixels, %0d register writes",
			blocks_sent, empty_blocks, pixels_checked, cfg_writes);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("timeout: decoder stopped making progress");
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/dxt_pkg.sv
hw/rtl/dxt_front.sv
hw/rtl/dxt_fifo.sv
hw/rtl/dxt_back.sv
hw/rtl/dxt_block_decoder.sv
bench/tb_top.sv
